// ----- design/clcg_pkg.sv -----
`default_nettype none

package clcg_pkg;

  // Part one: 40014 * s mod 2147483563, part two: 40692 * s mod 2147483399.
  localparam logic [15:0] LCG_A1 = 16'd40014;
  localparam logic [15:0] LCG_A2 = 16'd40692;
  localparam logic [30:0] LCG_M1 = 31'd2147483563;
  localparam logic [30:0] LCG_M2 = 31'd2147483399;

  // Each modulus is 2^31 minus a small constant, so 2^31 folds to that constant.
  localparam logic [7:0] LCG_C1 = 8'd85;
  localparam logic [7:0] LCG_C2 = 8'd249;

  // Combined outputs and window offsets live modulo m1 - 1.
  localparam logic [30:0] OUT_MOD = 31'd2147483562;

  localparam logic [9:0] TOLERANCE_RESET = 10'd100;

  // Configuration register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_TARGET_SECOND = 2'd0;
  localparam logic [1:0] REG_TARGET_THIRD  = 2'd1;
  localparam logic [1:0] REG_TOLERANCE     = 2'd2;

  typedef struct packed {
    logic [30:0] first;
    logic [30:0] second;
  } state_pair_t;

endpackage

`default_nettype wire

// ----- design/clcg_advance.sv -----
`default_nettype none

// Advances both generator parts by one step over three register stages:
// multiply, fold the bits above 2^31, then a second fold and final correction.
module clcg_advance
  import clcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire state_pair_t state,
  output state_pair_t      advanced
);

  logic [46:0] prod_first;
  logic [46:0] prod_second;
  logic [31:0] fold_first;
  logic [31:0] fold_second;

  // The folded value is below 2^31 + 2^24. When bit 31 is set the remainder
  // is the low part plus the fold constant, which is already below the modulus.
  function automatic logic [30:0] finish(input logic [31:0] f, input logic [7:0] c,
                                         input logic [30:0] m);
    logic [30:0] res;
    if (f[31]) begin
      res = f[30:0] + 31'(c);
    end else if (f[30:0] >= m) begin
      res = f[30:0] - m;
    end else begin
      res = f[30:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      prod_first  <= 47'(state.first) * 47'(LCG_A1);
      prod_second <= 47'(state.second) * 47'(LCG_A2);

      fold_first  <= 32'(prod_first[46:31]) * 32'(LCG_C1) + 32'(prod_first[30:0]);
      fold_second <= 32'(prod_second[46:31]) * 32'(LCG_C2) + 32'(prod_second[30:0]);

      advanced.first  <= finish(fold_first, LCG_C1, LCG_M1);
      advanced.second <= finish(fold_second, LCG_C2, LCG_M2);
    end
  end

endmodule

`default_nettype wire

// ----- design/clcg_window.sv -----
`default_nettype none

// Tests ((z + tol - center) mod (m1 - 1)) <= 2 * tol over four register stages.
// The center must already be reduced below m1 - 1.
module clcg_window
  import clcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] z,
  input  wire logic [9:0]  tol,
  input  wire logic [30:0] center,
  output logic             hit
);

  logic [31:0] sum;
  logic [30:0] reduced;
  logic [31:0] offset;
  logic [31:0] wrapped;
  logic [31:0] span;

  assign span    = 32'({tol, 1'b0});
  assign wrapped = offset + 32'(OUT_MOD);

  always_ff @(posedge clk) begin
    if (en) begin
      sum     <= 32'(z) + 32'(tol);
      reduced <= (sum >= 32'(OUT_MOD)) ? 31'(sum - 32'(OUT_MOD)) : sum[30:0];
      offset  <= 32'(reduced) - 32'(center);
      // A negative offset wraps once by the modulus.
      hit     <= offset[31] ? (wrapped <= span) : (offset <= span);
    end
  end

endmodule

`default_nettype wire

// ----- design/combined_lcg_state_check.sv -----
`default_nettype none

// Channel     Handshake                  Payload
// candidate   cand_valid / cand_stall    state_first, state_second
// result      result_valid / result_stall output_one, output_two, next_first,
//                                        next_second, match
// config      APB (psel, penable, ...)   target_second, target_third, tolerance
//
// One item per cycle is accepted unless a finished result is stalled. Each item
// passes two three-stage modular multiply pipelines in series, then a combine
// stage and the four-stage window test on the second output.
// Reset clears the valid bits and returns the registers to their defaults.
// While a finished result is stalled the whole pipeline holds and the
// candidate side is stalled; otherwise items keep flowing.
module combined_lcg_state_check
  import clcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        cand_valid,
  output logic             cand_stall,
  input  wire logic [30:0] state_first,
  input  wire logic [30:0] state_second,

  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [30:0]      output_one,
  output logic [30:0]      output_two,
  output logic [30:0]      next_first,
  output logic [30:0]      next_second,
  output logic             match,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned LAST = 10;

  logic [30:0] target_second;
  logic [30:0] target_third;
  logic [9:0]  tolerance;
  logic [30:0] center_second;
  logic [30:0] center_third;
  logic [30:0] center_next;
  logic        cfg_write;

  logic [LAST:0] valid;
  logic          adv;

  state_pair_t cand;
  state_pair_t state1;
  state_pair_t state2;
  state_pair_t state2_d [6:LAST];

  logic [30:0] z1;
  logic [30:0] z2;
  logic [30:0] z1_d [4:LAST];
  logic [30:0] z2_d [7:LAST];
  logic [31:0] diff1;
  logic [31:0] diff2;
  logic        hit1;
  logic        hit2;
  logic        hit1_d [8:LAST];

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign center_next = (pwdata[30:0] >= OUT_MOD) ? pwdata[30:0] - OUT_MOD : pwdata[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_second <= '0;
      target_third  <= '0;
      tolerance     <= TOLERANCE_RESET;
      center_second <= '0;
      center_third  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_TARGET_SECOND: begin
          target_second <= pwdata[30:0];
          center_second <= center_next;
        end
        REG_TARGET_THIRD: begin
          target_third <= pwdata[30:0];
          center_third <= center_next;
        end
        REG_TOLERANCE: begin
          tolerance <= pwdata[9:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TARGET_SECOND: prdata = 32'(target_second);
      REG_TARGET_THIRD:  prdata = 32'(target_third);
      REG_TOLERANCE:     prdata = 32'(tolerance);
      default:           prdata = '0;
    endcase
  end

  // Pipeline control: everything moves unless the finished item is held.
  assign adv          = !(valid[LAST] && result_stall);
  assign cand_stall   = !adv;
  assign result_valid = valid[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[LAST-1:0], cand_valid};
    end
  end

  assign cand.first  = state_first;
  assign cand.second = state_second;

  clcg_advance u_advance_one (
    .clk      (clk),
    .en       (adv),
    .state    (cand),
    .advanced (state1)
  );

  clcg_advance u_advance_two (
    .clk      (clk),
    .en       (adv),
    .state    (state1),
    .advanced (state2)
  );

  // Combined output: s1 - s2, plus m1 - 1 when the difference is below one.
  assign diff1 = 32'(state1.first) - 32'(state1.second);
  assign diff2 = 32'(state2.first) - 32'(state2.second);

  always_ff @(posedge clk) begin
    if (adv) begin
      z1 <= (diff1[31] || diff1 == '0) ? 31'(diff1 + 32'(OUT_MOD)) : diff1[30:0];
      z2 <= (diff2[31] || diff2 == '0) ? 31'(diff2 + 32'(OUT_MOD)) : diff2[30:0];

      z1_d[4] <= z1;
      for (int i = 5; i <= LAST; i++) begin
        z1_d[i] <= z1_d[i-1];
      end
      z2_d[7] <= z2;
      for (int i = 8; i <= LAST; i++) begin
        z2_d[i] <= z2_d[i-1];
      end
      state2_d[6] <= state2;
      for (int i = 7; i <= LAST; i++) begin
        state2_d[i] <= state2_d[i-1];
      end
      hit1_d[8] <= hit1;
      for (int i = 9; i <= LAST; i++) begin
        hit1_d[i] <= hit1_d[i-1];
      end
    end
  end

  clcg_window u_window_one (
    .clk    (clk),
    .en     (adv),
    .z      (z1),
    .tol    (tolerance),
    .center (center_second),
    .hit    (hit1)
  );

  clcg_window u_window_two (
    .clk    (clk),
    .en     (adv),
    .z      (z2),
    .tol    (tolerance),
    .center (center_third),
    .hit    (hit2)
  );

  assign output_one  = z1_d[LAST];
  assign output_two  = z2_d[LAST];
  assign next_first  = state2_d[LAST].first;
  assign next_second = state2_d[LAST].second;
  assign match       = hit1_d[LAST] && hit2;

endmodule

`default_nettype wire
